>>> design/dwo_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_pkg
// Shared types and constants of the dual wheel odometry and speed unit.
// ----------------------------------------------------------------------------
package dwo_pkg;

  // Drive states as they appear on the result
  localparam logic [1:0] DRV_RELEASE  = 2'd0;
  localparam logic [1:0] DRV_BRAKE    = 2'd1;
  localparam logic [1:0] DRV_FORWARD  = 2'd2;
  localparam logic [1:0] DRV_BACKWARD = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_MM_PER_TICK = 2'd0;
  localparam logic [1:0] REG_GAIN_P      = 2'd1;
  localparam logic [1:0] REG_GAIN_I      = 2'd2;
  localparam logic [1:0] REG_GAIN_D      = 2'd3;

  // distance * 1000 needs up to 50 bits (40-bit distance times 10 bits)
  localparam int DIV_BITS = 50;

  // Gains and scale, shared by all lanes
  typedef struct packed {
    logic [23:0] mm_per_tick;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
  } cfg_t;

  // Start request from the top level to the lanes
  typedef struct packed {
    logic               start;
    logic [15:0]        period;
    logic signed [15:0] target;
  } lane_cmd_t;

  // Per-lane result
  typedef struct packed {
    logic [10:0] duty;
    logic [1:0]  drive;
    logic [31:0] speed;
    logic [31:0] total;
  } lane_res_t;

endpackage

>>> design/dwo_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwo_lane
// One wheel: tick counter, odometry, bit-serial speed divider and PID step.
// ----------------------------------------------------------------------------
module dwo_lane #(
  parameter int PWM_FULL = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              edge_req,
  input  dwo_pkg::cfg_t     cfg,
  input  dwo_pkg::lane_cmd_t cmd,
  output logic              done,
  output dwo_pkg::lane_res_t res
);
  import dwo_pkg::*;

  localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;
  localparam logic signed [66:0] TERM_LIM = 67'sd1 <<< 53;
  localparam logic signed [66:0] PID_MAX = 67'(PWM_FULL) <<< 24;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_MUL  = 7'b0000010, S_DIV = 7'b0000100,
    S_ERR  = 7'b0001000, S_PROD = 7'b0010000, S_SUM = 7'b0100000,
    S_OUT  = 7'b1000000
  } lstate_t;

  lstate_t state;
  logic [15:0] tick_count;
  logic [31:0] total_mm;
  logic [15:0] fraction_tail;
  logic [31:0] speed_q16;
  logic [1:0]  drive_state;
  logic signed [32:0] last_error;
  logic signed [47:0] error_sum;

  logic [15:0] period;
  logic signed [15:0] target;
  logic [39:0] distance;
  logic [DIV_BITS-1:0] quo;
  logic [DIV_BITS-1:0] dvd;
  logic [16:0] rem;
  logic [5:0]  div_cnt;
  logic signed [32:0] err;
  logic signed [33:0] errd;
  logic signed [66:0] tp, ti, td;
  logic [10:0] duty;
  logic        skip;

  // one restoring divider step
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  assign rem_sh  = {rem[15:0], dvd[DIV_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, period};

  logic [40:0] acc;
  assign acc = {1'b0, distance} + {25'd0, fraction_tail};

  logic [1:0] want;
  assign want = target[15] ? DRV_BACKWARD : DRV_FORWARD;

  logic signed [48:0] sum_ext;
  logic signed [47:0] sum_new;
  assign sum_ext = 49'(error_sum) + 49'(err);
  assign sum_new = (sum_ext > 49'(SUM_MAX)) ? SUM_MAX :
                   (sum_ext < 49'(SUM_MIN)) ? SUM_MIN : sum_ext[47:0];

  logic signed [66:0] ti_raw, pid_raw;
  logic [66:0] pid;
  logic signed [16:0] ki_s;
  assign ki_s = {1'b0, cfg.ki};
  assign ti_raw = 67'(ki_s) * 67'(error_sum);
  assign pid_raw = tp + ti + td;
  assign pid = (pid_raw < 0) ? '0 : (pid_raw > PID_MAX) ? PID_MAX : pid_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tick_count <= '0;
      total_mm <= '0;
      fraction_tail <= '0;
      speed_q16 <= '0;
      drive_state <= DRV_RELEASE;
      last_error <= '0;
      error_sum <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (edge_req && tick_count != 16'hFFFF) tick_count <= tick_count + 16'd1;
          if (cmd.start) begin
            period   <= (cmd.period == 16'd0) ? 16'd1 : cmd.period;
            target   <= cmd.target;
            distance <= 40'(tick_count) * 40'(cfg.mm_per_tick);
            state    <= S_MUL;
          end
        end
        // distance*1000, odometry update
        S_MUL: begin
          dvd <= DIV_BITS'(distance) * DIV_BITS'(1000);
          rem <= '0;
          quo <= '0;
          div_cnt <= 6'(DIV_BITS);
          tick_count <= '0;
          total_mm <= total_mm + 32'(acc[40:16]);
          fraction_tail <= acc[15:0];
          state <= S_DIV;
        end
        // one quotient bit per cycle
        S_DIV: begin
          dvd <= {dvd[DIV_BITS-2:0], 1'b0};
          if (!rem_sub[16]) begin
            rem <= rem_sub;
            quo <= {quo[DIV_BITS-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[DIV_BITS-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == 6'd1) state <= S_ERR;
        end
        // saturate speed, decide brake or error
        S_ERR: begin
          speed_q16 <= (|quo[DIV_BITS-1:32]) ? 32'hFFFF_FFFF : quo[31:0];
          state <= S_PROD;
          skip <= 1'b0;
          if (target == 16'sd0) begin
            drive_state <= DRV_BRAKE;
            skip <= 1'b1;
          end else if (want != drive_state) begin
            if ((|quo[DIV_BITS-1:32]) || quo[31:0] > 32'd65536) begin
              drive_state <= DRV_BRAKE;
              skip <= 1'b1;
            end else begin
              last_error <= '0;
              error_sum <= '0;
            end
          end
        end
        S_PROD: begin
          err  <= 33'(target[15] ? -34'(target) : 34'(target)) * 33'sd65536
                  - 33'({1'b0, speed_q16});
          state <= skip ? S_OUT : S_SUM;
        end
        S_SUM: begin
          errd <= 34'(err) - 34'(last_error);
          error_sum <= sum_new;
          last_error <= err;
          tp <= 67'(signed'({1'b0, cfg.kp})) * 67'(err);
          state <= S_OUT;
          skip <= 1'b0;
        end
        default: begin
          if (skip) begin
            duty <= '0;
            done <= 1'b1;
            state <= S_IDLE;
          end else if (div_cnt == 6'd0) begin
            ti <= (ti_raw > TERM_LIM) ? TERM_LIM : (ti_raw < -TERM_LIM) ? -TERM_LIM : ti_raw;
            td <= 67'(signed'({1'b0, cfg.kd})) * 67'(errd);
            div_cnt <= 6'd1;
          end else begin
            duty <= pid[34:24];
            drive_state <= want;
            done <= 1'b1;
            div_cnt <= 6'd0;
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign res.duty  = duty;
  assign res.drive = drive_state;
  assign res.speed = speed_q16;
  assign res.total = total_mm;

  property p_done_idle;
    @(posedge clk) disable iff (rst) done |-> state == S_IDLE;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done outside idle");
  a_brake_duty: assert property (@(posedge clk) disable iff (rst)
    done && drive_state == DRV_BRAKE |-> duty == 11'd0) else $error("brake duty");
  a_tick_clr: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && $past(state) == S_MUL |-> tick_count == 16'd0)
    else $error("ticks kept");
endmodule

>>> design/dual_wheel_odometry_pid_speed_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_odometry_pid_speed_unit
// Two-wheel encoder odometry with a PID speed loop per wheel.
// ----------------------------------------------------------------------------
// Edge requests do not make the unit busy. The wheels of a heartbeat run in
// parallel lanes, each with a bit-serial speed divider (50 quotient bits, one
// per cycle). No new request is taken until the heartbeat's result has left
// the output register.
module dual_wheel_odometry_pid_speed_unit #(
  parameter int PWM_FULL = 1024,
  parameter int WHEELS = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  // tdata: left_edge, right_edge, period_ms[15:0], left_target, right_target
  input  logic [55:0] s_tdata,
  // tuser: mode
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tdata: left_duty, left_drive, right_duty, right_drive, left_speed_q16,
  // right_speed_q16, left_total_mm, right_total_mm
  output logic [159:0] m_tdata
);
  import dwo_pkg::*;

  cfg_t cfg;
  logic busy;
  logic [WHEELS-1:0] done_v, done_seen;
  lane_res_t res [WHEELS];
  lane_res_t r0, r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mm_per_tick <= 24'd65536;
      cfg.kp <= 16'd0;
      cfg.ki <= 16'd1101;
      cfg.kd <= 16'd102;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MM_PER_TICK: cfg.mm_per_tick <= cfg_data;
        REG_GAIN_P: cfg.kp <= cfg_data[15:0];
        REG_GAIN_I: cfg.ki <= cfg_data[15:0];
        REG_GAIN_D: cfg.kd <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !busy && !m_tvalid;
  logic acc_req;
  assign acc_req = s_tvalid && s_tready;

  // lanes
  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.start  = acc_req && s_tuser;
    assign cmd.period = s_tdata[17:2];
    assign cmd.target = (w == 0) ? s_tdata[33:18] : (w == 1) ? s_tdata[49:34] : 16'sd0;
    dwo_lane #(.PWM_FULL(PWM_FULL)) u_lane (
      .clk(clk), .rst(rst),
      .edge_req(acc_req && !s_tuser && ((w < 2) ? s_tdata[w % 2] : 1'b0)),
      .cfg(cfg), .cmd(cmd), .done(done_v[w]), .res(res[w]));
  end

  // merge: wait for all lanes, then register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      m_tvalid <= 1'b0;
      done_seen <= '0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (acc_req && s_tuser) busy <= 1'b1;
      if (busy) begin
        if ((done_seen | done_v) == {WHEELS{1'b1}}) begin
          busy <= 1'b0;
          m_tvalid <= 1'b1;
          done_seen <= '0;
          m_tdata <= {6'b0, r1.total, r0.total, r1.speed, r0.speed,
                      r1.drive, r1.duty, r0.drive, r0.duty};
        end else begin
          done_seen <= done_seen | done_v;
        end
      end
    end
  end

  assign r0 = res[0];
  assign r1 = (WHEELS > 1) ? res[WHEELS > 1 ? 1 : 0] : '0;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !busy) else $error("busy while result pending");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    acc_req |-> !m_tvalid) else $error("request taken over result");
  a_res_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(busy)) else $error("result without heartbeat");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual wheel odometry and PID speed unit.
// ----------------------------------------------------------------------------
// A driver feeds encoder edge and heartbeat requests from a queue. An
// in-bench model of both wheels predicts one result per heartbeat. A monitor
// compares each result field by field with the oldest prediction. Gains and
// scale change between phases, and only when the unit is idle. Both sides
// stall in random bursts, except during the long edge run and in the last phase.
// ----------------------------------------------------------------------------
module tb;
  import dwo_pkg::*;

  localparam int PWM_MAX = 1024;
  localparam int SETTLE = 64;
  localparam int STALL_LIMIT = 4000;
  localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint TERM_HI = 64'sd1 <<< 53;

  typedef struct {
    logic        beat;
    logic        left_edge;
    logic        right_edge;
    logic [15:0] period;
    logic [15:0] left_target;
    logic [15:0] right_target;
  } request_t;

  typedef struct {
    logic [10:0] duty [2];
    logic [1:0]  drive [2];
    logic [31:0] speed [2];
    logic [31:0] total [2];
  } wheel_result_t;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic [1:0]   cfg_index;
  logic [23:0]  cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [55:0]  s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;

  dual_wheel_odometry_pid_speed_unit u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Bench copy of configuration and per-wheel state
  logic [23:0] mm_per_tick;
  logic [15:0] kp, ki, kd;
  logic [15:0] ticks [2];
  logic [31:0] total_mm [2];
  logic [15:0] tail [2];
  logic [31:0] speed [2];
  logic [1:0]  drive [2];
  longint      last_err [2];
  longint      err_sum [2];

  request_t      pending [$];
  wheel_result_t expected_results [$];
  request_t      cur;
  int            errors = 0;
  bit            idle_en = 1'b1;
  int            gap = 0;
  int            stall = 0;
  int            quiet = 0;

  function automatic longint clamp(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one accepted request to the wheel model; heartbeats yield a result
  task automatic advance_wheels(request_t r);
    wheel_result_t res;
    longint period, distance, spd, acc, tgt, mag, err, errd, pid;
    logic [1:0] want;
    if (!r.beat) begin
      if (r.left_edge && ticks[0] != 16'hFFFF) ticks[0]++;
      if (r.right_edge && ticks[1] != 16'hFFFF) ticks[1]++;
      return;
    end
    period = (r.period == 0) ? 1 : longint'(r.period);
    for (int w = 0; w < 2; w++) begin
      // odometry
      distance = longint'(ticks[w]) * longint'(mm_per_tick);
      spd = distance * 1000 / period;
      ticks[w] = '0;
      speed[w] = (spd > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : spd[31:0];
      acc = distance + longint'(tail[w]);
      total_mm[w] = total_mm[w] + acc[47:16];
      tail[w] = acc[15:0];
      // speed loop
      tgt = (w == 0) ? longint'(signed'(r.left_target)) : longint'(signed'(r.right_target));
      res.duty[w] = '0;
      if (tgt == 0) begin
        drive[w] = DRV_BRAKE;
      end else begin
        want = (tgt > 0) ? DRV_FORWARD : DRV_BACKWARD;
        if (want != drive[w] && speed[w] > 32'd65536) begin
          drive[w] = DRV_BRAKE;
        end else begin
          if (want != drive[w]) begin
            last_err[w] = 0;
            err_sum[w] = 0;
          end
          mag = (tgt < 0) ? -tgt : tgt;
          err = mag * 65536 - longint'(speed[w]);
          errd = err - last_err[w];
          err_sum[w] = clamp(err_sum[w] + err, SUM_LO, SUM_HI);
          last_err[w] = err;
          pid = longint'(kp) * err + clamp(longint'(ki) * err_sum[w], -TERM_HI, TERM_HI)
                + longint'(kd) * errd;
          pid = clamp(pid, 0, longint'(PWM_MAX) <<< 24);
          drive[w] = want;
          res.duty[w] = pid[34:24];
        end
      end
      res.drive[w] = drive[w];
      res.speed[w] = speed[w];
      res.total[w] = total_mm[w];
    end
    expected_results.push_back(res);
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      s_tuser <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) advance_wheels(cur);
      if (!s_tvalid || s_tready) begin
        if (gap > 0) begin
          gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          cur = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur.beat;
          s_tdata <= {6'd0, cur.right_target, cur.left_target, cur.period,
                      cur.right_edge, cur.left_edge};
          if (idle_en && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 14);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor and result-side stalls
  always @(posedge clk) begin
    wheel_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result with no heartbeat pending");
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("left_duty", e.duty[0], m_tdata[10:0]);
          check_field("left_drive", e.drive[0], m_tdata[12:11]);
          check_field("right_duty", e.duty[1], m_tdata[23:13]);
          check_field("right_drive", e.drive[1], m_tdata[25:24]);
          check_field("left_speed_q16", e.speed[0], m_tdata[57:26]);
          check_field("right_speed_q16", e.speed[1], m_tdata[89:58]);
          check_field("left_total_mm", e.total[0], m_tdata[121:90]);
          check_field("right_total_mm", e.total[1], m_tdata[153:122]);
        end
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_edge(logic le, logic re);
    request_t r;
    r.beat = 1'b0;
    r.left_edge = le;
    r.right_edge = re;
    r.period = 16'($urandom);
    r.left_target = 16'($urandom);
    r.right_target = 16'($urandom);
    pending.push_back(r);
  endtask

  task automatic add_beat(logic [15:0] period, logic [15:0] lt, logic [15:0] rt);
    request_t r;
    r.beat = 1'b1;
    r.left_edge = 1'($urandom);
    r.right_edge = 1'($urandom);
    r.period = period;
    r.left_target = lt;
    r.right_target = rt;
    pending.push_back(r);
  endtask

  function automatic logic [15:0] rand_target();
    int sel;
    logic [15:0] v;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'h7FFF;
    if (sel == 2) return 16'h8000;
    if (sel == 3) return 16'($urandom);
    v = 16'($urandom_range(1, 800));
    return $urandom_range(0, 1) ? v : -v;
  endfunction

  function automatic logic [15:0] rand_period();
    int sel;
    sel = $urandom_range(0, 11);
    if (sel == 0) return 16'd0;
    if (sel == 1) return 16'hFFFF;
    if (sel == 2) return 16'($urandom);
    return 16'($urandom_range(1, 60));
  endfunction

  // Mostly edge bursts closed by a heartbeat; some stray back-to-back beats
  task automatic queue_random(int n);
    int k, burst;
    k = 0;
    while (k < n) begin
      burst = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
      for (int i = 0; i < burst; i++) add_edge(1'($urandom), 1'($urandom));
      add_beat(rand_period(), rand_target(), rand_target());
      k += burst + 1;
    end
  endtask

  task automatic wait_idle();
    while (pending.size() > 0 || s_tvalid || expected_results.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_MM_PER_TICK: mm_per_tick = val;
      REG_GAIN_P:      kp = val[15:0];
      REG_GAIN_I:      ki = val[15:0];
      default:         kd = val[15:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [23:0] mm, logic [15:0] p, logic [15:0] i, logic [15:0] d);
    wait_idle();
    write_reg(REG_MM_PER_TICK, mm);
    write_reg(REG_GAIN_P, {8'd0, p});
    write_reg(REG_GAIN_I, {8'd0, i});
    write_reg(REG_GAIN_D, {8'd0, d});
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MM_PER_TICK;
    cfg_data = '0;
    mm_per_tick = 24'd65536;
    kp = 16'd0;
    ki = 16'd1101;
    kd = 16'd102;
    for (int w = 0; w < 2; w++) begin
      ticks[w] = '0; total_mm[w] = '0; tail[w] = '0; speed[w] = '0;
      drive[w] = DRV_RELEASE; last_err[w] = 0; err_sum[w] = 0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset gains, zero period, extreme targets, ignored fields
    add_edge(1'b1, 1'b1);
    add_edge(1'b1, 1'b0);
    add_beat(16'd0, 16'h7FFF, 16'h8000);
    add_beat(16'hFFFF, 16'd0, 16'd0);
    for (int i = 0; i < 10; i++) add_edge(1'b1, 1'b1);
    add_beat(16'd5, 16'd100, 16'hFF9C);
    // direction change while still moving, then once stopped
    for (int i = 0; i < 10; i++) add_edge(1'b1, 1'b1);
    add_beat(16'd5, 16'hFF9C, 16'd100);
    add_beat(16'd5, 16'hFF9C, 16'd100);
    add_edge(1'b0, 1'b0);
    add_beat(16'd1, 16'd1, 16'hFFFF);
    queue_random(300);

    // Sender holds until the unit drains, then a long unbroken edge run
    wait_idle();
    idle_en = 1'b0;
    for (int i = 0; i < 100; i++) add_edge(1'b1, 1'b1);
    add_beat(16'd1, 16'd300, 16'hFED4);
    wait_idle();
    idle_en = 1'b1;

    set_config(24'd65536, 16'd256, 16'd1101, 16'd102);
    queue_random(300);
    set_config(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    for (int i = 0; i < 3; i++) add_edge(1'b1, 1'b1);
    add_beat(16'd1, 16'h7FFF, 16'h8000);
    queue_random(300);
    set_config(24'd1, 16'd0, 16'd0, 16'd0);
    queue_random(300);

    set_config(24'($urandom_range(20000, 200000)), 16'($urandom), 16'($urandom),
               16'($urandom));
    idle_en = 1'b0;
    queue_random(300);

    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
